// ===== sv/pfd_pkg.sv =====
// Shared constants, status codes and evaluation result type for the pressure frame deframer.
package pfd_pkg;

  localparam int WinLen  = 20;
  localparam int SrcPos  = 1;
  localparam int CsPos   = 18;
  localparam int TailPos = WinLen - 1;
  localparam int DataPos = 6;
  localparam int NumPads = 6;

  localparam int FillW = $clog2(WinLen + 1);

  localparam logic [7:0] HeaderReset  = 8'hF2;
  localparam logic [7:0] TrailerReset = 8'h00;
  localparam logic [7:0] SourceReset  = 8'h00;

  localparam logic [1:0] CfgHeader  = 2'd0;
  localparam logic [1:0] CfgTrailer = 2'd1;
  localparam logic [1:0] CfgSource  = 2'd2;

  localparam logic [2:0] StatusGood     = 3'd0;
  localparam logic [2:0] StatusNoHeader = 3'd1;
  localparam logic [2:0] StatusPrefix   = 3'd2;
  localparam logic [2:0] StatusTailBad  = 3'd3;
  localparam logic [2:0] StatusSrcBad   = 3'd4;
  localparam logic [2:0] StatusSumBad   = 3'd5;

  typedef logic [WinLen-1:0][7:0] frame_t;

  typedef struct packed {
    logic [2:0]                   status;
    logic [FillW-1:0]             drop;
    logic [NumPads-1:0][15:0]     pads;
  } eval_t;

endpackage

// ===== sv/pfd_frame_eval.sv =====
// Combinational check of one full 20-byte window and the shifted remainder.
module pfd_frame_eval import pfd_pkg::*; (
  input  frame_t     frame,
  input  logic [7:0] header_value,
  input  logic [7:0] trailer_value,
  input  logic [7:0] source_value,
  output eval_t      res,
  output frame_t     remain
);

  logic [FillW-1:0] hdr;
  logic [7:0]       sum;
  logic [7:0]       s1 [8];
  logic [7:0]       s2 [4];
  logic [7:0]       s3 [2];

  // First matching header byte wins, so scan from the top down.
  always_comb begin
    hdr = FillW'(WinLen);
    for (int i = WinLen - 1; i >= 0; i--) begin
      if (frame[i] == header_value) begin
        hdr = FillW'(i);
      end
    end
  end

  // Mod-256 sum of bytes 1 through 17 as a balanced adder tree.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      s1[i] = frame[SrcPos + 2*i] + frame[SrcPos + 2*i + 1];
    end
    for (int i = 0; i < 4; i++) begin
      s2[i] = s1[2*i] + s1[2*i + 1];
    end
    for (int i = 0; i < 2; i++) begin
      s3[i] = s2[2*i] + s2[2*i + 1];
    end
    sum = s3[0] + s3[1] + frame[CsPos - 1];
  end

  always_comb begin
    res.status = StatusGood;
    res.drop   = FillW'(WinLen);
    res.pads   = '0;
    if (hdr == FillW'(WinLen)) begin
      res.status = StatusNoHeader;
    end else if (hdr != '0) begin
      res.status = StatusPrefix;
      res.drop   = hdr;
    end else if (frame[TailPos] != trailer_value) begin
      res.status = StatusTailBad;
      res.drop   = FillW'(1);
    end else if (frame[SrcPos] != source_value) begin
      res.status = StatusSrcBad;
    end else if (sum != frame[CsPos]) begin
      res.status = StatusSumBad;
      res.drop   = FillW'(1);
    end else begin
      for (int k = 0; k < NumPads; k++) begin
        res.pads[k] = {frame[DataPos + 2*k], frame[DataPos + 2*k + 1]};
      end
    end
  end

  // Bytes past the dropped ones move down to the front of the window.
  assign remain = frame_t'(frame >> {res.drop, 3'b000});

endmodule

// ===== sv/pressure_frame_deframer.sv =====
// Top level of the pressure frame deframer: byte window, counters and result register.
// A result is registered when the byte completing the window leaves the input register.
// Throughput: one byte per cycle, sustained, as long as results are taken when offered.
// Each byte sits in an input register, then joins the window or completes it.
// Reset (rst, synchronous, active high) empties the window, clears both counters and both
// valid flags, and loads the header, trailer and source registers with their defaults.
module pressure_frame_deframer import pfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   rx_byte,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   status,
  output logic [15:0]  pad0,
  output logic [15:0]  pad1,
  output logic [15:0]  pad2,
  output logic [15:0]  pad3,
  output logic [15:0]  pad4,
  output logic [15:0]  pad5,
  output logic [31:0]  frames_total,
  output logic [31:0]  errors_total,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  // Configuration registers. Writes must land only while the block is idle; the
  // block does not enforce this. The port is always ready; an index past the list is dropped.
  logic [7:0] header_value;
  logic [7:0] trailer_value;
  logic [7:0] source_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value  <= HeaderReset;
      trailer_value <= TrailerReset;
      source_value  <= SourceReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgHeader:  header_value  <= cfg_data;
        CfgTrailer: trailer_value <= cfg_data;
        CfgSource:  source_value  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: one received byte waiting to join the window.
  logic       byte_valid;
  logic [7:0] byte_q;

  // The window holds the first fill bytes of the frame being assembled.
  // It never holds 20 bytes at rest: the twentieth is taken straight from
  // the input register when the window is evaluated.
  logic [7:0]       window [WinLen-1];
  logic [FillW-1:0] fill;
  logic [31:0]      good_count;
  logic [31:0]      bad_count;

  logic   complete;
  logic   advance;
  frame_t frame;
  frame_t remain;
  eval_t  res;

  logic [31:0] good_count_next;
  logic [31:0] bad_count_next;

  // A byte that completes the window needs room in the result register;
  // any other byte just moves into the window.
  assign complete = byte_valid && (fill == FillW'(WinLen - 1));
  assign advance  = byte_valid && (!complete || !out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      frame[i] = window[i];
    end
    frame[WinLen-1] = byte_q;
  end

  pfd_frame_eval u_eval (
    .frame         (frame),
    .header_value  (header_value),
    .trailer_value (trailer_value),
    .source_value  (source_value),
    .res           (res),
    .remain        (remain)
  );

  always_comb begin
    good_count_next = good_count;
    bad_count_next  = bad_count;
    if (res.status == StatusGood) begin
      good_count_next = good_count + 32'd1;
    end else begin
      bad_count_next = bad_count + 32'd1;
    end
  end

  // Window contents: the remainder after an evaluation, or the new byte
  // appended at the fill position. Entries above fill are never read.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (complete) begin
        for (int j = 0; j < WinLen - 1; j++) begin
          window[j] <= remain[j];
        end
      end else begin
        window[fill] <= byte_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      good_count <= '0;
      bad_count  <= '0;
    end else if (advance) begin
      if (complete) begin
        fill       <= FillW'(WinLen) - res.drop;
        good_count <= good_count_next;
        bad_count  <= bad_count_next;
      end else begin
        fill <= fill + FillW'(1);
      end
    end
  end

  // Result register. It refills in the same cycle that its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && complete) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && complete) begin
      status       <= res.status;
      pad0         <= res.pads[0];
      pad1         <= res.pads[1];
      pad2         <= res.pads[2];
      pad3         <= res.pads[3];
      pad4         <= res.pads[4];
      pad5         <= res.pads[5];
      frames_total <= good_count_next;
      errors_total <= bad_count_next;
    end
  end

endmodule

// ===== sv/pfd_checker.sv =====
// Port-level assertions for the pressure frame deframer, bound to the top level.
module pfd_assertions import pfd_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         out_valid,
  input logic         out_ready,
  input logic [2:0]   status,
  input logic [15:0]  pad0,
  input logic [15:0]  pad1,
  input logic [15:0]  pad2,
  input logic [15:0]  pad3,
  input logic [15:0]  pad4,
  input logic [15:0]  pad5,
  input logic [31:0]  frames_total,
  input logic [31:0]  errors_total
);

  // Only the six defined status codes ever leave the block.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= StatusSumBad))
    else $error("status code out of range");

  // A failed window carries no pad readings.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != StatusGood) |->
      (pad0 == '0 && pad1 == '0 && pad2 == '0 && pad3 == '0 &&
       pad4 == '0 && pad5 == '0))
    else $error("pads not zero on a failed window");

  // A stalled result beat holds its status and both counters.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(frames_total) && $stable(errors_total)))
    else $error("result beat changed while stalled");

  // Back-to-back results come from consecutive evaluations: exactly one
  // of the two counters advances by one.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) ##1 out_valid |->
      (32'(frames_total + errors_total) ==
       32'($past(frames_total + errors_total) + 32'd1)))
    else $error("counters did not advance by one between results");

endmodule

bind pressure_frame_deframer pfd_assertions u_pfd_assertions (.*);

// ===== tb/pfd_checker.sv =====
// Checker for the pressure frame deframer: watches all three channels, predicts, compares.
module pfd_checker import pfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [15:0] pad0,
  input  logic [15:0] pad1,
  input  logic [15:0] pad2,
  input  logic [15:0] pad3,
  input  logic [15:0] pad4,
  input  logic [15:0] pad5,
  input  logic [31:0] frames_total,
  input  logic [31:0] errors_total,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          pending,
  output int          mismatches
);

  typedef struct packed {
    logic [2:0]               status;
    logic [NumPads-1:0][15:0] pads;
    logic [31:0]              frames;
    logic [31:0]              errors;
  } verdict_t;

  verdict_t    pending_results[$];
  frame_t      window;
  int          fill;
  logic [31:0] good_frames;
  logic [31:0] drop_events;
  logic [7:0]  header_reg;
  logic [7:0]  trailer_reg;
  logic [7:0]  source_reg;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("pfd_checker: %s", msg);
  endtask

  // Appends one byte to the window and, once it is full, evaluates the frame.
  task automatic deframe_byte(input logic [7:0] b);
    int       hdr;
    int       drop;
    logic [7:0] sum;
    verdict_t v;
    window[fill] = b;
    fill++;
    if (fill < WinLen) return;
    v = '0;
    hdr = WinLen;
    for (int i = 0; i < WinLen; i++) begin
      if (hdr == WinLen && window[i] == header_reg) hdr = i;
    end
    sum = 8'h00;
    for (int i = SrcPos; i < CsPos; i++) sum += window[i];
    if (hdr == WinLen) begin
      v.status = StatusNoHeader;
      drop = WinLen;
    end else if (hdr > 0) begin
      v.status = StatusPrefix;
      drop = hdr;
    end else if (window[TailPos] != trailer_reg) begin
      v.status = StatusTailBad;
      drop = 1;
    end else if (window[SrcPos] != source_reg) begin
      v.status = StatusSrcBad;
      drop = WinLen;
    end else if (sum != window[CsPos]) begin
      v.status = StatusSumBad;
      drop = 1;
    end else begin
      v.status = StatusGood;
      drop = WinLen;
      for (int k = 0; k < NumPads; k++)
        v.pads[k] = {window[DataPos + 2 * k], window[DataPos + 2 * k + 1]};
    end
    for (int i = 0; i < WinLen - drop; i++) window[i] = window[i + drop];
    fill = WinLen - drop;
    if (v.status == StatusGood) good_frames++;
    else drop_events++;
    v.frames = good_frames;
    v.errors = drop_events;
    pending_results.push_back(v);
  endtask

  always @(posedge clk) begin : watch
    verdict_t got;
    verdict_t want;
    if (rst) begin
      window = '0;
      fill = 0;
      good_frames = '0;
      drop_events = '0;
      header_reg = HeaderReset;
      trailer_reg = TrailerReset;
      source_reg = SourceReset;
      pending_results.delete();
    end else begin
      // Results are compared before the new byte is absorbed; the block's latency
      // keeps a byte from producing its result on the edge that accepts it.
      if (out_valid && out_ready) begin
        got.status = status;
        got.pads = {pad5, pad4, pad3, pad2, pad1, pad0};
        got.frames = frames_total;
        got.errors = errors_total;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with status %0d but none expected", status));
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          for (int k = 0; k < NumPads; k++) begin
            if (got.pads[k] != want.pads[k])
              report_mismatch($sformatf("pad%0d %h, expected %h", k, got.pads[k],
                                        want.pads[k]));
          end
          if (got.frames != want.frames)
            report_mismatch($sformatf("frames_total %0d, expected %0d", got.frames,
                                      want.frames));
          if (got.errors != want.errors)
            report_mismatch($sformatf("errors_total %0d, expected %0d", got.errors,
                                      want.errors));
        end
      end
      if (in_valid && in_ready) deframe_byte(rx_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgHeader:  header_reg = cfg_data;
          CfgTrailer: trailer_reg = cfg_data;
          CfgSource:  source_reg = cfg_data;
          default:    ;
        endcase
      end
    end
    pending = pending_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the pressure frame deframer: stimulus, flow control and verdict.
module tb;
  import pfd_pkg::*;

  // The register file has three entries; the fourth index must be ignored.
  localparam logic [1:0] CfgUnused = 2'd3;

  // Roughly 1050 bytes, each waiting out at most one random sender gap, and each
  // result waiting out receiver stalls in the worst case, come to well under the
  // limit, which leaves several times the expected run length.
  localparam int CycleLimit = 400000;

  // Bytes sent per configuration setting; seven settings in all.
  localparam int PhaseBytes = 150;

  typedef enum {FrGood, FrTailBad, FrSrcBad, FrSumBad} frame_kind_t;
  typedef enum {RxOpen, RxCoin, RxSparse, RxTrickle} stall_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] pad0, pad1, pad2, pad3, pad4, pad5;
  logic [31:0] frames_total;
  logic [31:0] errors_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CfgHeader;
  logic [7:0]  cfg_data = 8'h00;

  int     pending;
  int     mismatches;
  int     cycles = 0;
  int     burst_left = 0;
  int     bytes_sent = 0;
  int     seg_cnt = 0;
  stall_t stall_mode = RxOpen;

  // Current register values, kept only so that the stimulus can build frames
  // that get past the header, tail and source checks.
  logic [7:0] cur_header = HeaderReset;
  logic [7:0] cur_trailer = TrailerReset;
  logic [7:0] cur_source = SourceReset;

  always #10 clk = ~clk;

  pressure_frame_deframer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .pad0(pad0), .pad1(pad1), .pad2(pad2), .pad3(pad3), .pad4(pad4), .pad5(pad5),
    .frames_total(frames_total), .errors_total(errors_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pfd_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .pad0(pad0), .pad1(pad1), .pad2(pad2), .pad3(pad3), .pad4(pad4), .pad5(pad5),
    .frames_total(frames_total), .errors_total(errors_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pending(pending), .mismatches(mismatches)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // The receiver picks a stall behavior at each wrap of its segment counter:
  // always ready, a coin toss, ready at multiples of eight on that counter, or
  // a sparse random trickle. The first drains at full rate; the rest back up.
  always @(posedge clk) begin
    if (seg_cnt == 0) stall_mode = stall_t'($urandom_range(0, 3));
    seg_cnt = (seg_cnt + 1) % 64;
    case (stall_mode)
      RxOpen:   out_ready <= 1'b1;
      RxCoin:   out_ready <= 1'($urandom_range(0, 1));
      RxSparse: out_ready <= (seg_cnt % 8 == 0);
      default:  out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Sends one beat. The sender works in bursts; when a burst is used up it drops
  // valid for a random gap first. Roughly one burst in four is long enough to
  // give a stretch with no idling at all.
  task automatic push_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 300 : $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
  endtask

  // Holds the sender off until every expected result has come back, then gives
  // the block extra time for any byte still sitting in its input register.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgHeader:  cur_header = data;
      CfgTrailer: cur_trailer = data;
      CfgSource:  cur_source = data;
      default:    ;
    endcase
    @(posedge clk);
  endtask

  // Builds a 20-byte frame under the current settings and sends it. A bad kind
  // corrupts exactly one of the tail, the source byte or the checksum.
  task automatic send_frame(input frame_kind_t kind,
                            input logic [NumPads-1:0][15:0] pads,
                            input logic [31:0] spare);
    frame_t     f;
    logic [7:0] sum;
    f = '0;
    f[0] = cur_header;
    f[SrcPos] = (kind == FrSrcBad) ? cur_source ^ 8'($urandom_range(1, 255)) : cur_source;
    for (int i = 0; i < 4; i++) f[2 + i] = spare[8 * i +: 8];
    for (int k = 0; k < NumPads; k++) begin
      f[DataPos + 2 * k] = pads[k][15:8];
      f[DataPos + 2 * k + 1] = pads[k][7:0];
    end
    sum = 8'h00;
    for (int i = SrcPos; i < CsPos; i++) sum += f[i];
    f[CsPos] = (kind == FrSumBad) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    f[TailPos] = (kind == FrTailBad) ? cur_trailer ^ 8'($urandom_range(1, 255)) : cur_trailer;
    for (int i = 0; i < WinLen; i++) push_byte(f[i]);
  endtask

  // Random traffic: mostly well-formed frames with random readings, plus frames
  // with one broken check, junk before a frame, and plain noise. Failures that
  // drop a single byte leave the window misaligned, so the following frames
  // exercise the prefix drop and resynchronization paths as well.
  task automatic run_mix(input int target);
    int                       start;
    int                       pick;
    logic [NumPads-1:0][15:0] pads;
    logic [7:0]               junk;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      pick = $urandom_range(0, 19);
      pads = {$urandom, $urandom, $urandom};
      if (pick < 10) begin
        send_frame(FrGood, pads, $urandom);
      end else if (pick < 12) begin
        send_frame(FrTailBad, pads, $urandom);
      end else if (pick < 14) begin
        send_frame(FrSrcBad, pads, $urandom);
      end else if (pick < 16) begin
        send_frame(FrSumBad, pads, $urandom);
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 6)) begin
          junk = 8'($urandom);
          if (junk == cur_header) junk = ~junk;
          push_byte(junk);
        end
        send_frame(FrGood, pads, $urandom);
      end else begin
        repeat ($urandom_range(1, 25)) push_byte(8'($urandom));
      end
      // Now and then the sender pauses until the block has fully drained.
      if ($urandom_range(0, 24) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opener under the reset settings: a good frame whose readings hit
    // all-ones, all-zeros and the mixed-byte patterns.
    send_frame(FrGood, {16'h7FFE, 16'h8001, 16'hFF00, 16'h00FF, 16'h0000, 16'hFFFF},
               32'h00FF00FF);
    run_mix(PhaseBytes - WinLen);

    // Each further setting starts from an idle block. The first two take the
    // extremes of every register; the rest are random. The unused index is hit
    // twice to show that such a write changes nothing.
    for (int phase = 1; phase < 7; phase++) begin
      wait_idle();
      case (phase)
        1: begin
          cfg_write(CfgHeader, 8'h00);
          cfg_write(CfgTrailer, 8'hFF);
          cfg_write(CfgSource, 8'hFF);
        end
        2: begin
          cfg_write(CfgHeader, 8'hFF);
          cfg_write(CfgTrailer, 8'h00);
          cfg_write(CfgSource, 8'h00);
          cfg_write(CfgUnused, 8'($urandom));
        end
        default: begin
          cfg_write(CfgHeader, 8'($urandom));
          cfg_write(CfgTrailer, 8'($urandom));
          cfg_write(CfgSource, 8'($urandom));
          if (phase == 4) cfg_write(CfgUnused, 8'($urandom));
        end
      endcase
      run_mix(PhaseBytes);
    end

    // Let the last results come back and let the block idle before the verdict.
    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
